### hw/rtl/thti_pkg.sv
// thti_pkg: widths, reference table, stage item types and helpers for the
// thermistor table interpolation pipeline. No dependencies.
package thti_pkg;

	localparam int SAMPLE_W = 10;
	localparam int CHAN_W   = 3;
	localparam int TEMP_W   = 11;
	localparam int TBL_FULL = 27;
	localparam int IDX_W    = 5;   // indexes 0..TBL_FULL-1
	localparam int DEN_W    = 7;   // largest gap between neighbors is 68
	localparam int REM_W    = 12;  // (hi - sample) * 50 < 3400
	localparam int QUO_W    = 6;   // fraction 0..49

	localparam int STEP_TENTHS = 50;
	localparam int BASE_TENTHS = 400;
	localparam int TABLE_ENTRIES_DEF = 27;

	// descending converter readings, entry i is -40 + 5*i degrees
	localparam logic [SAMPLE_W-1:0] NTC_TABLE [TBL_FULL] = '{
		10'd923, 10'd890, 10'd848, 10'd799, 10'd742, 10'd680, 10'd614,
		10'd546, 10'd480, 10'd416, 10'd358, 10'd305, 10'd258, 10'd217,
		10'd183, 10'd153, 10'd129, 10'd108, 10'd91,  10'd76,  10'd64,
		10'd55,  10'd46,  10'd39,  10'd34,  10'd29,  10'd25
	};

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [CHAN_W-1:0]   channel;
		logic                fail;
		logic [IDX_W-1:0]    idx;
	} srch_t;

	typedef struct packed {
		logic [CHAN_W-1:0]          channel;
		logic                       fail;
		logic signed [TEMP_W-1:0]   base;
		logic [REM_W-1:0]           rem;
		logic [DEN_W-1:0]           den;
		logic [QUO_W-1:0]           quot;
	} div_t;

	// table read, zero outside the table
	function automatic logic [SAMPLE_W-1:0] tbl_at(input logic [IDX_W-1:0] i);
		logic [SAMPLE_W-1:0] v;
		v = '0;
		if (int'(i) < TBL_FULL) begin
			v = NTC_TABLE[i];
		end
		return v;
	endfunction

endpackage

### hw/rtl/thti_search.sv
// thti_search: stage 1, range check and table search of the sample.
// Uses thti_pkg.
module thti_search #(
	parameter int TABLE_ENTRIES = thti_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  logic [thti_pkg::SAMPLE_W-1:0] sample,
	input  logic [thti_pkg::CHAN_W-1:0]   channel,
	output logic                          valid_s1,
	output thti_pkg::srch_t               item_s1
);
	import thti_pkg::*;

	localparam int N  = (TABLE_ENTRIES > TBL_FULL) ? TBL_FULL :
	                    (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
	localparam int NG = N - 1;

	logic [TBL_FULL-1:0] gt;
	srch_t               nxt;

	// gt is a run of ones from entry 0; idx is where the run ends
	always_comb begin
		gt = '0;
		for (int i = 0; i < TBL_FULL - 1; i++) begin
			if (i < NG) begin
				gt[i] = NTC_TABLE[i] > sample;
			end
		end
		nxt.sample  = sample;
		nxt.channel = channel;
		nxt.fail    = (sample > NTC_TABLE[0]) || (sample < NTC_TABLE[N-1]);
		nxt.idx     = '0;
		for (int i = 0; i < TBL_FULL - 1; i++) begin
			if (gt[i] && !gt[i+1]) begin
				nxt.idx = nxt.idx | IDX_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

endmodule

### hw/rtl/thti_prep.sv
// thti_prep: stage 2, neighbor lookup, exact-match check, dividend and
// divisor for the interpolation fraction. Uses thti_pkg.
module thti_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_s1,
	input  thti_pkg::srch_t item_s1,
	output logic            valid_s2,
	output thti_pkg::div_t  item_s2
);
	import thti_pkg::*;

	logic [SAMPLE_W-1:0] lo;
	logic [SAMPLE_W-1:0] hi;
	logic [SAMPLE_W-1:0] diff;
	logic [SAMPLE_W-1:0] gap;
	logic [IDX_W-1:0]    base_idx;
	logic                exact;
	div_t                nxt;

	always_comb begin
		lo       = tbl_at(item_s1.idx);
		hi       = tbl_at(item_s1.idx - 1'b1);
		exact    = (lo == item_s1.sample) || (item_s1.idx == '0);
		base_idx = exact ? item_s1.idx : item_s1.idx - 1'b1;
		diff     = hi - item_s1.sample;
		gap      = hi - lo;
		nxt.channel = item_s1.channel;
		nxt.fail    = item_s1.fail;
		nxt.quot    = '0;
		if (item_s1.fail) begin
			nxt.base = '0;
			nxt.rem  = '0;
			nxt.den  = DEN_W'(1);
		end else if (exact) begin
			nxt.base = TEMP_W'(int'(base_idx) * STEP_TENTHS - BASE_TENTHS);
			nxt.rem  = '0;
			nxt.den  = DEN_W'(1);
		end else begin
			nxt.base = TEMP_W'(int'(base_idx) * STEP_TENTHS - BASE_TENTHS);
			nxt.rem  = REM_W'(diff[DEN_W-1:0]) * REM_W'(STEP_TENTHS);
			nxt.den  = gap[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= nxt;
		end
	end

endmodule

### hw/rtl/thti_div_stage.sv
// thti_div_stage: one stage of the restoring divider, two quotient bits
// from HI_BIT down. Uses thti_pkg.
module thti_div_stage #(
	parameter int HI_BIT = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  thti_pkg::div_t item_in,
	output logic           valid_out,
	output thti_pkg::div_t item_out
);
	import thti_pkg::*;

	logic [REM_W-1:0] d_sh;
	div_t             nxt;

	always_comb begin
		nxt  = item_in;
		d_sh = '0;
		for (int k = 0; k < 2; k++) begin
			d_sh = REM_W'(item_in.den) << (HI_BIT - k);
			if (nxt.rem >= d_sh) begin
				nxt.rem              = nxt.rem - d_sh;
				nxt.quot[HI_BIT - k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_out <= nxt;
		end
	end

endmodule

### hw/rtl/thermistor_table_interpolation.sv
// thermistor_table_interpolation: five-stage pipeline from converter sample
// to temperature in tenths of a degree. Uses thti_pkg and its submodules.
// Throughput: one item per cycle while out_stall is low; a stalled output
// holds its item and bubbles in earlier stages still fill behind it.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
module thermistor_table_interpolation #(
	parameter int TABLE_ENTRIES = thti_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [thti_pkg::SAMPLE_W-1:0]       sample,
	input  logic [thti_pkg::CHAN_W-1:0]         channel,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [thti_pkg::TEMP_W-1:0]  temp_tenths,
	output logic                                fail,
	output logic [thti_pkg::CHAN_W-1:0]         channel_out
);
	import thti_pkg::*;

	// Stage map:
	//   s1  range check, search for first entry not above the sample
	//   s2  neighbor lookup, exact match, dividend (hi-sample)*50, divisor
	//   s3  quotient bits 5,4
	//   s4  quotient bits 3,2
	//   s5  quotient bits 1,0; output = base + quotient
	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic  en_s1, en_s2, en_s3, en_s4, en_s5;
	srch_t item_s1;
	div_t  item_s2, item_s3, item_s4, item_s5;

	// A stage loads when it is empty or its contents move on.
	assign en_s5 = !v_s5 || !out_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_stall = !en_s1;

	thti_search #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_s1),
		.valid_in (in_valid),
		.sample   (sample),
		.channel  (channel),
		.valid_s1 (v_s1),
		.item_s1  (item_s1)
	);

	thti_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_s2),
		.valid_s1 (v_s1),
		.item_s1  (item_s1),
		.valid_s2 (v_s2),
		.item_s2  (item_s2)
	);

	thti_div_stage #(.HI_BIT(5)) u_div_s3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_s3),
		.valid_in  (v_s2),
		.item_in   (item_s2),
		.valid_out (v_s3),
		.item_out  (item_s3)
	);

	thti_div_stage #(.HI_BIT(3)) u_div_s4 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_s4),
		.valid_in  (v_s3),
		.item_in   (item_s3),
		.valid_out (v_s4),
		.item_out  (item_s4)
	);

	thti_div_stage #(.HI_BIT(1)) u_div_s5 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_s5),
		.valid_in  (v_s4),
		.item_in   (item_s4),
		.valid_out (v_s5),
		.item_out  (item_s5)
	);

	// fail and exact items carry a zero dividend, so quotient is 0 for them
	assign out_valid   = v_s5;
	assign temp_tenths = TEMP_W'(item_s5.base) + TEMP_W'(item_s5.quot);
	assign fail        = item_s5.fail;
	assign channel_out = item_s5.channel;

endmodule

### tb/thermistor_table_interpolation_tb.sv
// thermistor_table_interpolation_tb: self-checking bench for the thermistor table
// interpolation pipeline. It drives samples and checks temperatures against a predictor
// built from thti_pkg constants. Depends on thti_pkg and thermistor_table_interpolation.
module thermistor_table_interpolation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import thti_pkg::*;

	localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
	// entries actually searched; the block clamps the parameter to 2..27
	localparam int N_USED = (TABLE_ENTRIES > TBL_FULL) ? TBL_FULL :
		(TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_LEN    = 80;   // long receiver hold-off, in cycles
	localparam int DRAIN_WAIT  = 12;   // wait after the queue drains, to catch stray results
	localparam int MAX_REPORTS = 10;

	// corner samples: table ends, one past each end, exact entries and neighbors
	localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [24] = '{
		10'd0,   10'd1023, 10'd924, 10'd923, 10'd922, 10'd891,
		10'd890, 10'd889,  10'd546, 10'd513, 10'd217, 10'd200,
		10'd91,  10'd34,   10'd30,  10'd29,  10'd26,  10'd25,
		10'd24,  10'd512,  10'd511, 10'd256, 10'd128, 10'd1
	};

	// one expected conversion result
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     fail;
		logic [CHAN_W-1:0]        chan;
	} reading_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [SAMPLE_W-1:0]        sample = '0;
	logic [CHAN_W-1:0]          channel = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [TEMP_W-1:0]   temp_tenths;
	logic                       fail;
	logic [CHAN_W-1:0]          channel_out;

	reading_t reading_q [$];      // expected results, oldest first

	int  cycle_count = 0;
	int  mismatch_count = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_out_of_range = 0;
	int  stall_left = 0;
	int  hold_req = 0;            // bumped by a test to request a long hold-off
	int  hold_served = 0;
	bit  rx_random_en = 1'b0;     // receiver stalls at random when set
	bit  tx_gaps_en = 1'b0;       // sender idles at random between items

	thermistor_table_interpolation #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.channel    (channel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.temp_tenths(temp_tenths),
		.fail       (fail),
		.channel_out(channel_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, reading_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Converts a raw sample the way the block should: find the first entry at or
	// below the sample, then interpolate linearly from the entry above it.
	function automatic reading_t convert_reading(input logic [SAMPLE_W-1:0] s,
			input logic [CHAN_W-1:0] ch);
		reading_t r;
		int       k;
		int       t;
		int       upper;
		int       lower;
		r.chan = ch;
		r.fail = 1'b0;
		t = 0;
		if (s > NTC_TABLE[0] || s < NTC_TABLE[N_USED-1]) begin
			// open or shorted sensor
			r.fail = 1'b1;
		end else begin
			k = 0;
			while (k < N_USED - 1 && NTC_TABLE[k] > s) k++;
			if (NTC_TABLE[k] == s || k == 0) begin
				t = k * STEP_TENTHS - BASE_TENTHS;
			end else begin
				upper = NTC_TABLE[k-1];
				lower = NTC_TABLE[k];
				t = (k - 1) * STEP_TENTHS - BASE_TENTHS
					+ ((upper - int'(s)) * STEP_TENTHS) / (upper - lower);
			end
		end
		r.temp = t[TEMP_W-1:0];
		return r;
	endfunction

	// Random sample weighted toward the interesting spots: exact entries, their
	// neighbors, both out-of-range bands, and the whole 10-bit range.
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int v;
		v = 0;
		case ($urandom_range(0, 9))
			0, 1: begin
				v = NTC_TABLE[$urandom_range(0, N_USED - 1)];
			end
			2: begin
				v = NTC_TABLE[$urandom_range(0, N_USED - 1)];
				v = $urandom_range(0, 1) ? v + 1 : v - 1;
			end
			3: begin
				v = $urandom_range(0, 1) ? $urandom_range(0, NTC_TABLE[N_USED-1] - 1)
					: $urandom_range(NTC_TABLE[0] + 1, 1023);
			end
			4: begin
				v = $urandom_range(0, 1023);
			end
			default: begin
				v = $urandom_range(NTC_TABLE[N_USED-1], NTC_TABLE[0]);
			end
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	// Receiver side: random stalls, mostly short, now and then long, plus the
	// long hold-off a test can request. Counted here, one cycle at a time.
	always @(posedge clk) begin
		if (hold_req != hold_served) begin
			hold_served <= hold_served + 1;
			stall_left <= HOLD_LEN - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (rx_random_en && $urandom_range(0, 99) < 25) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
				: $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker: every accepted result is matched against the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reading_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: temp %0d fail %0b ch %0d",
						temp_tenths, fail, channel_out);
			end else begin
				want = reading_q.pop_front();
				n_checked++;
				if (want.fail) n_out_of_range++;
				if (temp_tenths !== want.temp || fail !== want.fail
						|| channel_out !== want.chan) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"mismatch on result %0d: expected temp %0d ",
							"fail %0b ch %0d, got temp %0d fail %0b ch %0d"},
							n_checked, want.temp, want.fail, want.chan,
							temp_tenths, fail, channel_out);
				end
			end
		end
	end

	// Offer one item and hold it until the block takes it. Valid stays high on
	// return so a back-to-back item follows without a bubble.
	task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] ch);
		in_valid <= 1'b1;
		sample <= s;
		channel <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		reading_q.push_back(convert_reading(s, ch));
		n_sent++;
	endtask

	// Sender idle time: mostly none, some short gaps, a few long ones.
	task automatic sender_gap();
		int n;
		n = 0;
		if (tx_gaps_en) begin
			case ($urandom_range(0, 19))
				0: n = $urandom_range(10, 40);
				1, 2, 3, 4, 5, 6: n = $urandom_range(1, 3);
				default: n = 0;
			endcase
		end
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		while (reading_q.size() != 0) @(posedge clk);
	endtask

	// Corner samples on every channel, with light idling on both sides.
	task automatic test_corner_samples();
		rx_random_en <= 1'b1;
		tx_gaps_en = 1'b1;
		foreach (EDGE_SAMPLES[i]) begin
			send_item(EDGE_SAMPLES[i], CHAN_W'(i % 8));
			sender_gap();
		end
		send_item(10'd480, 3'd7);
		sender_gap();
	endtask

	task automatic test_random_stream(input int count);
		rx_random_en <= 1'b1;
		tx_gaps_en = 1'b1;
		repeat (count) begin
			send_item(rand_sample(), CHAN_W'($urandom_range(0, 7)));
			sender_gap();
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps pushing;
	// the pipeline fills up and must stall its input without losing items.
	// Random receiver stalls come back with the next test.
	task automatic test_back_pressure();
		tx_gaps_en = 1'b0;
		rx_random_en <= 1'b0;
		hold_req <= hold_req + 1;
		repeat (40) send_item(rand_sample(), CHAN_W'($urandom_range(0, 7)));
	endtask

	// Bursts separated by a full drain, so the block restarts from empty.
	task automatic test_sender_pause();
		rx_random_en <= 1'b1;
		tx_gaps_en = 1'b1;
		repeat (3) begin
			repeat (15) begin
				send_item(rand_sample(), CHAN_W'($urandom_range(0, 7)));
				sender_gap();
			end
			in_valid <= 1'b0;
			wait_all_results();
			@(posedge clk);
		end
	endtask

	// Full rate on both sides: one item in and one result out per cycle, once any
	// leftover receiver stall has run out. Random receiver stalls come back with the next test.
	task automatic test_full_rate(input int count);
		tx_gaps_en = 1'b0;
		rx_random_en <= 1'b0;
		repeat (count) send_item(rand_sample(), CHAN_W'($urandom_range(0, 7)));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_samples();
		test_random_stream(300);
		test_back_pressure();
		test_sender_pause();
		test_full_rate(100);
		test_random_stream(280);

		in_valid <= 1'b0;
		wait_all_results();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (reading_q.size() != 0) begin
			mismatch_count += reading_q.size();
			$display("%0d expected results never arrived", reading_q.size());
		end
		$display("Converted %0d samples across all 8 channels, %0d of them out of range;",
			n_checked, n_out_of_range);
		$display("covered corner samples, random idling, a long output hold and full-rate runs.");
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
